### design/tvd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tvd_pkg: shared types, constants and arithmetic helpers
// Word formats, state encodings and the Q16.16 saturating helpers used by
// the TV-L1 denoiser sequencer and its stopping-test unit.
// ---------------------------------------------------------------------------
package tvd_pkg;

   localparam int MAX_ROWS   = 64;
   localparam int MAX_COLS   = 64;
   localparam int DATA_WIDTH = 32;

   localparam int ADDR_BITS  = $clog2(MAX_ROWS * MAX_COLS);
   localparam int ROW_BITS   = $clog2(MAX_ROWS + 1);
   localparam int COL_BITS   = $clog2(MAX_COLS + 1);
   localparam int WIDE_BITS  = DATA_WIDTH + 8;
   localparam int MUL_BITS   = DATA_WIDTH + 3;
   localparam int Q_BITS     = 32;

   // Stopping-test accumulator widths.
   localparam int CHG_BITS   = 2 * DATA_WIDTH + ADDR_BITS;
   localparam int NRM_BITS   = 2 * DATA_WIDTH - 1 + ADDR_BITS;
   localparam int CHUNK_BITS = (NRM_BITS + 2) / 3;
   localparam int NRM_PAD    = 3 * CHUNK_BITS;
   localparam int RHS_BITS   = NRM_PAD + Q_BITS;
   localparam int CMP_BITS   = CHG_BITS + Q_BITS;

   localparam logic [Q_BITS-1:0] TAU_Q32     = 32'd48318382;
   localparam logic [Q_BITS-1:0] CP_GAIN_Q32 = 32'd4247186448;
   localparam int SIGMA = 10;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_RUN  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [2:0] REG_ROWS  = 3'd0;
   localparam logic [2:0] REG_COLS  = 3'd1;
   localparam logic [2:0] REG_LAMBDA = 3'd2;
   localparam logic [2:0] REG_ALG   = 3'd3;
   localparam logic [2:0] REG_LIMIT = 3'd4;
   localparam logic [2:0] REG_TOL   = 3'd5;

   localparam logic signed [WIDE_BITS-1:0] SAT_HI =
      WIDE_BITS'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
   localparam logic signed [WIDE_BITS-1:0] SAT_LO = -SAT_HI - WIDE_BITS'(1);

   typedef struct packed {
      logic [1:0]                   opcode;
      logic [ADDR_BITS-1:0]         pixel_index;
      logic signed [DATA_WIDTH-1:0] pixel_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] out_value;
      logic [15:0]                  iterations_used;
   } rsp_type;

   typedef struct packed {
      logic                  we;
      logic [ADDR_BITS-1:0]  waddr;
      logic [DATA_WIDTH-1:0] wdata;
      logic                  re;
      logic [ADDR_BITS-1:0]  raddr;
   } mem_ctl_type;

   typedef struct packed {
      logic clear;
      logic sample;
      logic finish;
   } stop_ctl_type;

   typedef struct packed {
      logic busy;
      logic converged;
   } stop_status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_READ,
      S_I_RD0, S_I_RD1, S_I_RD2, S_I_WR,
      S_P_RD0, S_P_RD1, S_P_D, S_P_M1, S_P_M2, S_P_WR,
      S_CHK_GO, S_CHK_WAIT,
      S_D_RD0, S_D_RD1, S_D_RD2, S_D_WR,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_WAIT, ST_MUL, ST_ADD, ST_CMP
   } stop_state_type;

   // Saturate a wide signed value to the data width.
   function automatic logic signed [DATA_WIDTH-1:0] sat_dw(
      input logic signed [WIDE_BITS-1:0] v);
      logic signed [WIDE_BITS-1:0] r;
      r = v;
      if (v > SAT_HI) r = SAT_HI;
      if (v < SAT_LO) r = SAT_LO;
      return r[DATA_WIDTH-1:0];
   endfunction

   // Signed value times an unsigned Q0.32 constant, rounded half away from zero.
   function automatic logic signed [MUL_BITS-1:0] mulq_q32(
      input logic signed [MUL_BITS-1:0] a, input logic [Q_BITS-1:0] c);
      logic [MUL_BITS-1:0]        mag;
      logic [MUL_BITS+Q_BITS-1:0] prod;
      logic [MUL_BITS-1:0]        r;
      mag  = a[MUL_BITS-1] ? MUL_BITS'(-a) : MUL_BITS'(a);
      prod = (MUL_BITS+Q_BITS)'(mag) * (MUL_BITS+Q_BITS)'(c)
           + (MUL_BITS+Q_BITS)'(64'h8000_0000);
      r    = prod[MUL_BITS+Q_BITS-1:Q_BITS];
      return a[MUL_BITS-1] ? -$signed(r) : $signed(r);
   endfunction

endpackage
`default_nettype wire

### design/tvd_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tvd_ram: single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle; read data holds when idle.
// ---------------------------------------------------------------------------
module tvd_ram #(
   parameter int WIDTH     = 32,
   parameter int ADDR_BITS = 12
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [ADDR_BITS-1:0] waddr,
   input  wire logic [WIDTH-1:0]     wdata,
   input  wire logic                 re,
   input  wire logic [ADDR_BITS-1:0] raddr,
   output logic      [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem [2**ADDR_BITS];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

### design/tvd_stop.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tvd_stop: stopping test for one iteration
// Accumulates the squared change and squared norm, then checks
// change * 2^32 <= tol * norm with a chunked multiply.
// ---------------------------------------------------------------------------
module tvd_stop (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire tvd_pkg::stop_ctl_type                ctl,
   input  wire logic signed [tvd_pkg::DATA_WIDTH-1:0] x,
   input  wire logic signed [tvd_pkg::DATA_WIDTH-1:0] xt,
   input  wire logic [tvd_pkg::Q_BITS-1:0]           tol,
   output tvd_pkg::stop_status_type                  status
);

   localparam int DW = tvd_pkg::DATA_WIDTH;

   tvd_pkg::stop_state_type state_ff, state_in;

   logic                             sv_ff;
   logic [2*DW-1:0]                  chg_sq_ff, nrm_sq_ff;
   logic [tvd_pkg::CHG_BITS-1:0]     chg_ff, chg_in;
   logic [tvd_pkg::NRM_PAD-1:0]      nrm_ff, nrm_in;
   logic [tvd_pkg::RHS_BITS-1:0]     rhs_ff, rhs_in;
   logic [tvd_pkg::CHUNK_BITS+tvd_pkg::Q_BITS-1:0] prod_ff, prod_in;
   logic [1:0]                       k_ff, k_in;
   logic                             conv_ff, conv_in;

   logic signed [DW:0] dif, xs;
   logic [DW:0]        ad_w, ax_w;
   logic [DW-1:0]      ad, ax;
   logic [tvd_pkg::CHUNK_BITS-1:0] chunk;

   always_comb begin
      dif  = (DW+1)'(xt) - (DW+1)'(x);
      xs   = (DW+1)'(x);
      ad_w = dif[DW] ? (DW+1)'(-dif) : (DW+1)'(dif);
      ax_w = xs[DW] ? (DW+1)'(-xs) : (DW+1)'(xs);
      ad   = ad_w[DW-1:0];
      ax   = ax_w[DW-1:0];
   end

   // Squares are registered before they are summed.
   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= 1'b0;
      end else begin
         sv_ff <= ctl.sample;
      end
      if (ctl.sample) begin
         chg_sq_ff <= (2*DW)'(ad) * (2*DW)'(ad);
         nrm_sq_ff <= (2*DW)'(ax) * (2*DW)'(ax);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tvd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      chg_ff  <= chg_in;
      nrm_ff  <= nrm_in;
      rhs_ff  <= rhs_in;
      prod_ff <= prod_in;
      k_ff    <= k_in;
      conv_ff <= conv_in;
   end

   always_comb begin
      state_in = state_ff;
      chg_in   = chg_ff;
      nrm_in   = nrm_ff;
      rhs_in   = rhs_ff;
      prod_in  = prod_ff;
      k_in     = k_ff;
      conv_in  = conv_ff;
      case (k_ff)
         2'd0:    chunk = nrm_ff[0 +: tvd_pkg::CHUNK_BITS];
         2'd1:    chunk = nrm_ff[tvd_pkg::CHUNK_BITS +: tvd_pkg::CHUNK_BITS];
         default: chunk = nrm_ff[2*tvd_pkg::CHUNK_BITS +: tvd_pkg::CHUNK_BITS];
      endcase
      if (ctl.clear) begin
         chg_in = '0;
         nrm_in = '0;
      end else if (sv_ff) begin
         chg_in = chg_ff + tvd_pkg::CHG_BITS'(chg_sq_ff);
         nrm_in = nrm_ff + tvd_pkg::NRM_PAD'(nrm_sq_ff);
      end
      case (state_ff)
         tvd_pkg::ST_IDLE: begin
            if (ctl.finish) begin
               state_in = tvd_pkg::ST_WAIT;
               rhs_in   = '0;
               k_in     = 2'd0;
            end
         end
         tvd_pkg::ST_WAIT: begin
            if (!sv_ff) begin
               state_in = tvd_pkg::ST_MUL;
            end
         end
         tvd_pkg::ST_MUL: begin
            prod_in  = (tvd_pkg::CHUNK_BITS+tvd_pkg::Q_BITS)'(chunk)
                     * (tvd_pkg::CHUNK_BITS+tvd_pkg::Q_BITS)'(tol);
            state_in = tvd_pkg::ST_ADD;
         end
         tvd_pkg::ST_ADD: begin
            case (k_ff)
               2'd0:    rhs_in = rhs_ff + tvd_pkg::RHS_BITS'(prod_ff);
               2'd1:    rhs_in = rhs_ff + (tvd_pkg::RHS_BITS'(prod_ff)
                                           << tvd_pkg::CHUNK_BITS);
               default: rhs_in = rhs_ff + (tvd_pkg::RHS_BITS'(prod_ff)
                                           << (2*tvd_pkg::CHUNK_BITS));
            endcase
            if (k_ff == 2'd2) begin
               state_in = tvd_pkg::ST_CMP;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = tvd_pkg::ST_MUL;
            end
         end
         tvd_pkg::ST_CMP: begin
            conv_in  = {chg_ff, {tvd_pkg::Q_BITS{1'b0}}}
                       <= tvd_pkg::CMP_BITS'(rhs_ff);
            state_in = tvd_pkg::ST_IDLE;
         end
         default: state_in = tvd_pkg::ST_IDLE;
      endcase
   end

   assign status.busy      = (state_ff != tvd_pkg::ST_IDLE);
   assign status.converged = conv_ff;

endmodule
`default_nettype wire

### design/tv_denoise_primal_dual_2d.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tv_denoise_primal_dual_2d: anisotropic TV-L1 image denoiser
// Primal-dual iteration over five pixel RAMs in Q16.16 fixed point.
// ---------------------------------------------------------------------------
//
//   channel | ports                          | direction | word
//   --------+--------------------------------+-----------+---------------------
//   request | req_valid, req_stall, req_word | in        | opcode, index, value
//   result  | rsp_valid, rsp_stall, rsp_word | out       | value, iterations
//   control | csr_wr_en, csr_index, csr_wr_data | in     | register write
//
// A load writes one word to the noisy store and a read fetches one word of
// the solution; each returns one result word. A run does a setup sweep, then
// per iteration a primal sweep (with an extra multiply for the prox step),
// the stopping test and a dual sweep; the single read port of each pixel
// RAM sets the pace of each sweep. The request side is stalled for the
// whole run, and also whenever the result register is full and stalled.
// Reset is synchronous, clears control state and sets the configuration
// registers to defaults; the pixel RAMs hold no defined contents until loaded.
//
module tv_denoise_primal_dual_2d (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire tvd_pkg::req_type      req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output tvd_pkg::rsp_type           rsp_word,
   input  wire logic                  csr_wr_en,
   input  wire logic [2:0]            csr_index,
   input  wire logic [31:0]           csr_wr_data
);

   localparam int DW = tvd_pkg::DATA_WIDTH;
   localparam int AW = tvd_pkg::ADDR_BITS;
   localparam int WB = tvd_pkg::WIDE_BITS;
   localparam int MB = tvd_pkg::MUL_BITS;

   // Configuration registers.
   logic [6:0]  rows_ff, cols_ff;
   logic [30:0] weight_ff;
   logic        alg_ff;
   logic [15:0] limit_ff;
   logic [31:0] tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff   <= 7'd64;
         cols_ff   <= 7'd64;
         weight_ff <= 31'd65536;
         alg_ff    <= 1'b0;
         limit_ff  <= 16'd1000;
         tol_ff    <= 32'd0;
      end else if (csr_wr_en) begin
         case (csr_index)
            tvd_pkg::REG_ROWS:   rows_ff   <= csr_wr_data[6:0];
            tvd_pkg::REG_COLS:   cols_ff   <= csr_wr_data[6:0];
            tvd_pkg::REG_LAMBDA: weight_ff <= csr_wr_data[30:0];
            tvd_pkg::REG_ALG:    alg_ff    <= csr_wr_data[0];
            tvd_pkg::REG_LIMIT:  limit_ff  <= csr_wr_data[15:0];
            tvd_pkg::REG_TOL:    tol_ff    <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // The image size is clamped into the range the stores can hold.
   logic [tvd_pkg::ROW_BITS-1:0] m_eff;
   logic [tvd_pkg::COL_BITS-1:0] n_eff;

   always_comb begin
      m_eff = tvd_pkg::ROW_BITS'(rows_ff);
      if (rows_ff < 7'd2) m_eff = tvd_pkg::ROW_BITS'(2);
      if (rows_ff > 7'(tvd_pkg::MAX_ROWS)) m_eff = tvd_pkg::ROW_BITS'(tvd_pkg::MAX_ROWS);
      n_eff = tvd_pkg::COL_BITS'(cols_ff);
      if (cols_ff < 7'd2) n_eff = tvd_pkg::COL_BITS'(2);
      if (cols_ff > 7'(tvd_pkg::MAX_COLS)) n_eff = tvd_pkg::COL_BITS'(tvd_pkg::MAX_COLS);
   end

   // Pixel stores: noisy input Y, solution X, vertical dual P, horizontal
   // dual Q and the over-relaxed work image W.
   tvd_pkg::mem_ctl_type ym, xm, pm, qm, wm;
   logic [DW-1:0] y_rd, x_rd, p_rd, q_rd, w_rd;

   tvd_ram #(.WIDTH(DW), .ADDR_BITS(AW)) u_noisy (
      .clock(clock), .we(ym.we), .waddr(ym.waddr), .wdata(ym.wdata),
      .re(ym.re), .raddr(ym.raddr), .rdata(y_rd));
   tvd_ram #(.WIDTH(DW), .ADDR_BITS(AW)) u_solution (
      .clock(clock), .we(xm.we), .waddr(xm.waddr), .wdata(xm.wdata),
      .re(xm.re), .raddr(xm.raddr), .rdata(x_rd));
   tvd_ram #(.WIDTH(DW), .ADDR_BITS(AW)) u_dual_v (
      .clock(clock), .we(pm.we), .waddr(pm.waddr), .wdata(pm.wdata),
      .re(pm.re), .raddr(pm.raddr), .rdata(p_rd));
   tvd_ram #(.WIDTH(DW), .ADDR_BITS(AW)) u_dual_h (
      .clock(clock), .we(qm.we), .waddr(qm.waddr), .wdata(qm.wdata),
      .re(qm.re), .raddr(qm.raddr), .rdata(q_rd));
   tvd_ram #(.WIDTH(DW), .ADDR_BITS(AW)) u_work (
      .clock(clock), .we(wm.we), .waddr(wm.waddr), .wdata(wm.wdata),
      .re(wm.re), .raddr(wm.raddr), .rdata(w_rd));

   tvd_pkg::stop_ctl_type    stop_ctl;
   tvd_pkg::stop_status_type stop_status;
   logic signed [DW-1:0]     xt_val, z_val;

   // Sequencer state and operand registers. The four operand registers are
   // shared between phases: during setup x_ff and y_ff hold Y[p] and
   // Y[p+1]; in the primal sweep they hold X[p] and Y[p] while pv_ff and
   // qv_ff hold the upper and left duals; in the dual sweep they hold W[p]
   // and W[p+1] while pv_ff and qv_ff hold P[p] and Q[p].
   tvd_pkg::state_type state_ff, state_in;
   logic [AW-1:0]                 p_ff, p_in;
   logic [tvd_pkg::ROW_BITS-1:0]  i_ff, i_in;
   logic [tvd_pkg::COL_BITS-1:0]  j_ff, j_in;
   logic [15:0]                   it_ff, it_in, count_ff, count_in;
   logic                          done_ff, done_in;
   logic signed [DW-1:0]          x_ff, x_in, y_ff, y_in, pv_ff, pv_in, qv_ff, qv_in;
   logic signed [DW-1:0]          d_ff, d_in;
   logic signed [MB-1:0]          mr_ff, mr_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   tvd_pkg::rsp_type              rsp_word_ff, rsp_word_in;

   // Stopping-test unit.
   tvd_stop u_stop (
      .clock(clock), .reset(reset), .ctl(stop_ctl),
      .x(x_ff), .xt(xt_val), .tol(tol_ff), .status(stop_status));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tvd_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         it_ff        <= '0;
         done_ff      <= 1'b0;
         p_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         it_ff        <= it_in;
         done_ff      <= done_in;
         p_ff         <= p_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
      end
      x_ff        <= x_in;
      y_ff        <= y_in;
      pv_ff       <= pv_in;
      qv_ff       <= qv_in;
      d_ff        <= d_in;
      mr_ff       <= mr_in;
      rsp_word_ff <= rsp_word_in;
   end

   // Neighbor addresses and the raster step through the image.
   logic [AW-1:0] m_addr, p_up, p_dn, p_right, p_left;
   logic          row_end, last_px, has_below, has_right;
   logic [AW-1:0] adv_p;
   logic [tvd_pkg::ROW_BITS-1:0] adv_i;
   logic [tvd_pkg::COL_BITS-1:0] adv_j;

   always_comb begin
      m_addr    = AW'(m_eff);
      p_up      = p_ff - AW'(1);
      p_dn      = p_ff + AW'(1);
      p_left    = p_ff - m_addr;
      p_right   = p_ff + m_addr;
      row_end   = (i_ff == m_eff - tvd_pkg::ROW_BITS'(1));
      last_px   = row_end && (j_ff == n_eff - tvd_pkg::COL_BITS'(1));
      has_below = !row_end;
      has_right = (j_ff != n_eff - tvd_pkg::COL_BITS'(1));
      adv_p     = p_ff + AW'(1);
      adv_i     = row_end ? '0 : i_ff + tvd_pkg::ROW_BITS'(1);
      adv_j     = row_end ? j_ff + tvd_pkg::COL_BITS'(1) : j_ff;
   end

   // Datapath: shared Q0.32 multiplier, primal result and dual updates.
   logic signed [MB-1:0] mul_a, mul_r;
   logic [31:0]          mul_c;
   logic signed [WB-1:0] lam, dv_raw, dh_raw;
   logic signed [DW-1:0] dv_sat, dh_sat, dv_new, dh_new, init_dv, init_dh;

   always_comb begin
      if (state_ff == tvd_pkg::S_P_M2) begin
         mul_a = MB'(x_ff) + mr_ff;
         mul_c = tvd_pkg::CP_GAIN_Q32;
      end else if (alg_ff) begin
         mul_a = MB'(y_ff) - MB'(d_ff);
         mul_c = tvd_pkg::TAU_Q32;
      end else begin
         mul_a = MB'(x_ff) - MB'(y_ff) + MB'(d_ff);
         mul_c = tvd_pkg::TAU_Q32;
      end
      mul_r = tvd_pkg::mulq_q32(mul_a, mul_c);

      xt_val = alg_ff ? tvd_pkg::sat_dw(WB'(mr_ff))
                      : tvd_pkg::sat_dw(WB'(x_ff) - WB'(mr_ff));
      z_val  = tvd_pkg::sat_dw(WB'(xt_val) + WB'(xt_val) - WB'(x_ff));

      init_dv = tvd_pkg::sat_dw(WB'(y_ff) - WB'(x_ff));
      init_dh = tvd_pkg::sat_dw(WB'($signed(y_rd)) - WB'(x_ff));

      // Dual ascent with sigma, then clamp to plus or minus lambda.
      lam    = WB'({1'b0, weight_ff});
      dv_raw = WB'(pv_ff) + WB'(tvd_pkg::SIGMA) * (WB'(y_ff) - WB'(x_ff));
      dh_raw = WB'(qv_ff) + WB'(tvd_pkg::SIGMA) * (WB'($signed(w_rd)) - WB'(x_ff));
      dv_sat = tvd_pkg::sat_dw(dv_raw);
      dh_sat = tvd_pkg::sat_dw(dh_raw);
      dv_new = dv_sat;
      if (WB'(dv_sat) > lam)  dv_new = DW'(lam);
      if (WB'(dv_sat) < -lam) dv_new = DW'(-lam);
      dh_new = dh_sat;
      if (WB'(dh_sat) > lam)  dh_new = DW'(lam);
      if (WB'(dh_sat) < -lam) dh_new = DW'(-lam);
   end

   logic rsp_free;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != tvd_pkg::S_IDLE) || (rsp_valid_ff && rsp_stall);

   // Next state, memory ports and register next values.
   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      it_in        = it_ff;
      done_in      = done_ff;
      count_in     = count_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      pv_in        = pv_ff;
      qv_in        = qv_ff;
      d_in         = d_ff;
      mr_in        = mr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      ym = '0;
      xm = '0;
      pm = '0;
      qm = '0;
      wm = '0;
      stop_ctl = '0;

      case (state_ff)
         tvd_pkg::S_IDLE: begin
            if (req_valid && !req_stall) begin
               case (req_word.opcode)
                  tvd_pkg::OP_LOAD: begin
                     ym.we    = 1'b1;
                     ym.waddr = req_word.pixel_index;
                     ym.wdata = req_word.pixel_value;
                     rsp_valid_in = 1'b1;
                     rsp_word_in.out_value       = '0;
                     rsp_word_in.iterations_used = count_ff;
                  end
                  tvd_pkg::OP_READ: begin
                     xm.re    = 1'b1;
                     xm.raddr = req_word.pixel_index;
                     state_in = tvd_pkg::S_READ;
                  end
                  tvd_pkg::OP_RUN: begin
                     p_in     = '0;
                     i_in     = '0;
                     j_in     = '0;
                     it_in    = '0;
                     done_in  = 1'b0;
                     state_in = tvd_pkg::S_I_RD0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_word_in.out_value       = '0;
                     rsp_word_in.iterations_used = count_ff;
                  end
               endcase
            end
         end
         tvd_pkg::S_READ: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in.out_value       = $signed(x_rd);
               rsp_word_in.iterations_used = count_ff;
               state_in = tvd_pkg::S_IDLE;
            end
         end

         // Setup: X = Y and the duals start as forward differences of Y.
         tvd_pkg::S_I_RD0: begin
            ym.re    = 1'b1;
            ym.raddr = p_ff;
            state_in = tvd_pkg::S_I_RD1;
         end
         tvd_pkg::S_I_RD1: begin
            x_in     = $signed(y_rd);
            ym.re    = 1'b1;
            ym.raddr = p_dn;
            state_in = tvd_pkg::S_I_RD2;
         end
         tvd_pkg::S_I_RD2: begin
            y_in     = $signed(y_rd);
            ym.re    = 1'b1;
            ym.raddr = p_right;
            state_in = tvd_pkg::S_I_WR;
         end
         tvd_pkg::S_I_WR: begin
            xm.we    = 1'b1;
            xm.waddr = p_ff;
            xm.wdata = x_ff;
            pm.we    = 1'b1;
            pm.waddr = p_ff;
            pm.wdata = has_below ? init_dv : '0;
            qm.we    = 1'b1;
            qm.waddr = p_ff;
            qm.wdata = has_right ? init_dh : '0;
            if (last_px) begin
               p_in = '0;
               i_in = '0;
               j_in = '0;
               if (limit_ff == '0) begin
                  state_in = tvd_pkg::S_DONE;
               end else begin
                  it_in    = 16'd1;
                  stop_ctl.clear = 1'b1;
                  state_in = tvd_pkg::S_P_RD0;
               end
            end else begin
               p_in     = adv_p;
               i_in     = adv_i;
               j_in     = adv_j;
               state_in = tvd_pkg::S_I_RD0;
            end
         end

         // Primal sweep: divergence, primal step, over-relaxation.
         tvd_pkg::S_P_RD0: begin
            pm.re    = 1'b1;
            pm.raddr = p_up;
            qm.re    = 1'b1;
            qm.raddr = p_left;
            xm.re    = 1'b1;
            xm.raddr = p_ff;
            ym.re    = 1'b1;
            ym.raddr = p_ff;
            state_in = tvd_pkg::S_P_RD1;
         end
         tvd_pkg::S_P_RD1: begin
            pv_in    = (i_ff != '0) ? $signed(p_rd) : '0;
            qv_in    = (j_ff != '0) ? $signed(q_rd) : '0;
            x_in     = $signed(x_rd);
            y_in     = $signed(y_rd);
            pm.re    = 1'b1;
            pm.raddr = p_ff;
            qm.re    = 1'b1;
            qm.raddr = p_ff;
            state_in = tvd_pkg::S_P_D;
         end
         tvd_pkg::S_P_D: begin
            d_in = tvd_pkg::sat_dw(WB'(pv_ff) - WB'($signed(p_rd))
                                   + WB'(qv_ff) - WB'($signed(q_rd)));
            state_in = tvd_pkg::S_P_M1;
         end
         tvd_pkg::S_P_M1: begin
            mr_in    = mul_r;
            state_in = alg_ff ? tvd_pkg::S_P_M2 : tvd_pkg::S_P_WR;
         end
         tvd_pkg::S_P_M2: begin
            mr_in    = mul_r;
            state_in = tvd_pkg::S_P_WR;
         end
         tvd_pkg::S_P_WR: begin
            xm.we    = 1'b1;
            xm.waddr = p_ff;
            xm.wdata = xt_val;
            wm.we    = 1'b1;
            wm.waddr = p_ff;
            wm.wdata = z_val;
            stop_ctl.sample = 1'b1;
            if (last_px) begin
               state_in = tvd_pkg::S_CHK_GO;
            end else begin
               p_in     = adv_p;
               i_in     = adv_i;
               j_in     = adv_j;
               state_in = tvd_pkg::S_P_RD0;
            end
         end
         tvd_pkg::S_CHK_GO: begin
            stop_ctl.finish = 1'b1;
            state_in = tvd_pkg::S_CHK_WAIT;
         end
         tvd_pkg::S_CHK_WAIT: begin
            if (!stop_status.busy) begin
               done_in  = stop_status.converged;
               p_in     = '0;
               i_in     = '0;
               j_in     = '0;
               state_in = tvd_pkg::S_D_RD0;
            end
         end

         // Dual sweep: ascent on the forward differences of W.
         tvd_pkg::S_D_RD0: begin
            wm.re    = 1'b1;
            wm.raddr = p_ff;
            pm.re    = 1'b1;
            pm.raddr = p_ff;
            qm.re    = 1'b1;
            qm.raddr = p_ff;
            state_in = tvd_pkg::S_D_RD1;
         end
         tvd_pkg::S_D_RD1: begin
            x_in     = $signed(w_rd);
            pv_in    = $signed(p_rd);
            qv_in    = $signed(q_rd);
            wm.re    = 1'b1;
            wm.raddr = p_dn;
            state_in = tvd_pkg::S_D_RD2;
         end
         tvd_pkg::S_D_RD2: begin
            y_in     = $signed(w_rd);
            wm.re    = 1'b1;
            wm.raddr = p_right;
            state_in = tvd_pkg::S_D_WR;
         end
         tvd_pkg::S_D_WR: begin
            pm.we    = has_below;
            pm.waddr = p_ff;
            pm.wdata = dv_new;
            qm.we    = has_right;
            qm.waddr = p_ff;
            qm.wdata = dh_new;
            if (last_px) begin
               p_in = '0;
               i_in = '0;
               j_in = '0;
               if (done_ff || (it_ff == limit_ff)) begin
                  state_in = tvd_pkg::S_DONE;
               end else begin
                  it_in    = it_ff + 16'd1;
                  stop_ctl.clear = 1'b1;
                  state_in = tvd_pkg::S_P_RD0;
               end
            end else begin
               p_in     = adv_p;
               i_in     = adv_i;
               j_in     = adv_j;
               state_in = tvd_pkg::S_D_RD0;
            end
         end
         tvd_pkg::S_DONE: begin
            if (rsp_free) begin
               count_in     = it_ff;
               rsp_valid_in = 1'b1;
               rsp_word_in.out_value       = '0;
               rsp_word_in.iterations_used = it_ff;
               state_in = tvd_pkg::S_IDLE;
            end
         end
         default: state_in = tvd_pkg::S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // A vertical dual written by the ascent step never leaves the lambda box.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == tvd_pkg::S_D_WR && pm.we) |->
         ($signed(pm.wdata) <= $signed({1'b0, weight_ff}) &&
          $signed(pm.wdata) >= -$signed({1'b0, weight_ff})))
      else $error("vertical dual outside lambda bound");

   // Every primal sweep runs with an iteration number inside the limit.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == tvd_pkg::S_P_RD0) |-> (it_ff != 16'd0 && it_ff <= limit_ff))
      else $error("iteration counter outside limit");

   // The stopping test starts only from the check request.
   assert property (@(posedge clock) disable iff (reset)
      $rose(stop_status.busy) |-> ($past(state_ff) == tvd_pkg::S_CHK_GO))
      else $error("stop unit started outside check");

endmodule
`default_nettype wire
